[rtl/r2fft_pkg.sv]
// Shared constants, types and twiddle ROM for the radix-2 FFT block.
// No dependencies.
package r2fft_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int DW = 16;
    localparam int IW = 6;

    localparam logic [0:0] REG_LOG2 = 1'b0;
    localparam logic [0:0] REG_INV  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic         wr_in;
        logic [IW-1:0] in_addr;
        logic         rd;
        logic [IW-1:0] rd_addr;
        logic         bf_cap_a;
        logic         bf_cap_b;
        logic         bf_wr_a;
        logic         bf_wr_b;
        logic [IW-1:0] wr_addr;
        logic [4:0]   tw;
        logic         inv;
    } cmd_t;

    // Quarter-wave sine, Q1.15
    function automatic logic signed [16:0] sine_q(input logic [4:0] k);
        logic signed [16:0] v;
        case (k)
            5'd0:  v = 17'sd0;
            5'd1:  v = 17'sd3212;
            5'd2:  v = 17'sd6393;
            5'd3:  v = 17'sd9512;
            5'd4:  v = 17'sd12540;
            5'd5:  v = 17'sd15447;
            5'd6:  v = 17'sd18205;
            5'd7:  v = 17'sd20788;
            5'd8:  v = 17'sd23170;
            5'd9:  v = 17'sd25330;
            5'd10: v = 17'sd27246;
            5'd11: v = 17'sd28899;
            5'd12: v = 17'sd30274;
            5'd13: v = 17'sd31357;
            5'd14: v = 17'sd32138;
            5'd15: v = 17'sd32610;
            5'd16: v = 17'sd32767;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/r2fft_ram.sv]
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module r2fft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/r2fft_datapath.sv]
// Point store and butterfly datapath of the radix-2 FFT.
// Depends on r2fft_pkg and r2fft_ram.
module r2fft_datapath
    import r2fft_pkg::*;
(
    input  logic                 clk,
    input  cmd_t                 cmd,
    input  logic signed [DW-1:0] in_re,
    input  logic signed [DW-1:0] in_im,
    output logic signed [DW-1:0] rd_re,
    output logic signed [DW-1:0] rd_im
);
    logic signed [DW-1:0] ar_reg, ai_reg;
    logic signed [DW-1:0] pr_reg, pi_reg, qr_reg, qi_reg;
    logic signed [33:0]   m1_reg, m2_reg, m3_reg, m4_reg;
    logic                 we;
    logic [IW-1:0]        waddr;
    logic [DW-1:0]        wre, wim;
    logic signed [16:0]   c, s, ws;
    logic [4:0]           t;

    function automatic logic signed [DW-1:0] satf(input logic signed [18:0] v);
        if (v > 19'sd32767)
            return 16'sh7fff;
        else if (v < -19'sd32768)
            return 16'sh8000;
        else
            return v[DW-1:0];
    endfunction

    // Write mux: input load or butterfly results
    always_comb
    begin
        we    = cmd.wr_in | cmd.bf_wr_a | cmd.bf_wr_b;
        waddr = cmd.wr_in ? cmd.in_addr : cmd.wr_addr;
        if (cmd.wr_in)
        begin
            wre = in_re;
            wim = in_im;
        end
        else if (cmd.bf_wr_a)
        begin
            wre = pr_reg;
            wim = pi_reg;
        end
        else
        begin
            wre = qr_reg;
            wim = qi_reg;
        end
    end

    r2fft_ram #(.WIDTH(DW), .DEPTH(64)) u_re (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wre), .raddr(cmd.rd_addr), .rdata(rd_re)
    );
    r2fft_ram #(.WIDTH(DW), .DEPTH(64)) u_im (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wim), .raddr(cmd.rd_addr), .rdata(rd_im)
    );

    // Twiddle lookup
    always_comb
    begin
        t = cmd.tw;
        if (t <= 5'd16)
        begin
            c = sine_q(5'd16 - t);
            s = sine_q(t);
        end
        else
        begin
            c = -sine_q(t - 5'd16);
            s = sine_q(5'd0 - t);
        end
        ws = cmd.inv ? s : -s;
    end

    // Operand capture, products, then sums
    always_ff @(posedge clk)
    begin
        logic signed [34:0] tr, ti;
        logic signed [18:0] p0, p1, q0, q1;
        if (cmd.bf_cap_a)
        begin
            ar_reg <= rd_re;
            ai_reg <= rd_im;
        end
        if (cmd.bf_cap_b)
        begin
            m1_reg <= 34'(rd_re * c);
            m2_reg <= 34'(rd_im * ws);
            m3_reg <= 34'(rd_im * c);
            m4_reg <= 34'(rd_re * ws);
        end
        tr = (35'(m1_reg) - 35'(m2_reg) + 35'sd16384) >>> 15;
        ti = (35'(m3_reg) + 35'(m4_reg) + 35'sd16384) >>> 15;
        p0 = 19'(ar_reg) + tr[18:0];
        p1 = 19'(ai_reg) + ti[18:0];
        q0 = 19'(ar_reg) - tr[18:0];
        q1 = 19'(ai_reg) - ti[18:0];
        if (!cmd.inv)
        begin
            p0 = (p0 + 19'sd1) >>> 1;
            p1 = (p1 + 19'sd1) >>> 1;
            q0 = (q0 + 19'sd1) >>> 1;
            q1 = (q1 + 19'sd1) >>> 1;
        end
        pr_reg <= satf(p0);
        pi_reg <= satf(p1);
        qr_reg <= satf(q0);
        qi_reg <= satf(q1);
    end
endmodule

[rtl/r2fft_ctrl.sv]
// Sequencer for load, butterfly stages and output of the radix-2 FFT.
// Depends on r2fft_pkg.
module r2fft_ctrl
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic [0:0]    cfg_index,
    input  logic [2:0]    cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [IW-1:0] out_idx,
    output logic          out_last,
    output cmd_t          cmd
);
    localparam int LMAX = (MAX_POINTS >= 64) ? 6 : $clog2(MAX_POINTS + 1) - 1;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_BF   = 3'd1;
    localparam logic [2:0] S_OUT  = 3'd2;

    logic [2:0]    state_reg;
    logic [2:0]    l2_reg;
    logic          inv_reg;
    logic [IW-1:0] cnt_reg;
    logic [2:0]    stage_reg;
    logic [IW-1:0] bf_reg;
    logic [2:0]    ph_reg;
    logic [IW:0]   oc_reg;
    logic          ov_reg;
    logic [IW-1:0] oidx_reg;
    logic          olast_reg;
    logic [2:0]    bits;
    logic [IW-1:0] nm1, rev, a_addr, b_addr, half, jj, tmul;

    always_comb
    begin
        bits = (l2_reg == 3'd0) ? 3'd1 : ((l2_reg > 3'(LMAX)) ? 3'(LMAX) : l2_reg);
        nm1  = IW'((7'd1 << bits) - 7'd1);
        rev  = '0;
        for (int b = 0; b < IW; b++)
        begin
            if (b < bits)
            begin
                rev[bits - 3'd1 - 3'(b)] = cnt_reg[b];
            end
        end
        // butterfly bf_reg in stage: group index above stage bits, j below
        half   = IW'(7'd1 << stage_reg);
        jj     = bf_reg & (half - 1'b1);
        a_addr = ((bf_reg & ~(half - 1'b1)) << 1) | jj;
        b_addr = a_addr | half;
        tmul   = IW'(jj << (3'd5 - stage_reg));
    end

    // no new sample until the last point of the previous frame is taken
    assign in_ready  = (state_reg == S_LOAD) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_idx   = oidx_reg;
    assign out_last  = olast_reg;

    // Command decode
    always_comb
    begin
        cmd          = '0;
        cmd.inv      = inv_reg;
        cmd.in_addr  = rev;
        cmd.wr_in    = in_valid && in_ready;
        cmd.tw       = tmul[4:0];
        cmd.wr_addr  = (ph_reg == 3'd5) ? b_addr : a_addr;
        if (state_reg == S_BF)
        begin
            cmd.rd       = 1'b1;
            cmd.rd_addr  = (ph_reg == 3'd0) ? a_addr : b_addr;
            cmd.bf_cap_a = (ph_reg == 3'd1);
            cmd.bf_cap_b = (ph_reg == 3'd2);
            cmd.bf_wr_a  = (ph_reg == 3'd4);
            cmd.bf_wr_b  = (ph_reg == 3'd5);
        end
        else
        begin
            // keep reading the shown point while it waits
            cmd.rd_addr = ov_reg ? oidx_reg : oc_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            l2_reg    <= 3'd6;
            inv_reg   <= 1'b0;
            cnt_reg   <= '0;
            stage_reg <= '0;
            bf_reg    <= '0;
            ph_reg    <= '0;
            oc_reg    <= '0;
            ov_reg    <= 1'b0;
            oidx_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_LOG2)
                begin
                    l2_reg  <= cfg_data;
                    cnt_reg <= '0;
                end
                else
                begin
                    inv_reg <= cfg_data[0];
                end
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (in_valid && !ov_reg)
                    begin
                        if (cnt_reg == nm1)
                        begin
                            cnt_reg   <= '0;
                            stage_reg <= '0;
                            bf_reg    <= '0;
                            ph_reg    <= '0;
                            state_reg <= S_BF;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_BF:
                begin
                    if (ph_reg == 3'd5)
                    begin
                        ph_reg <= '0;
                        if (bf_reg == (nm1 >> 1))
                        begin
                            bf_reg <= '0;
                            if (stage_reg == bits - 3'd1)
                            begin
                                oc_reg    <= '0;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                stage_reg <= stage_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            bf_reg <= bf_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                S_OUT:
                begin
                    // read issued at oc; store data is valid with ov and held until taken
                    if (!ov_reg || out_ready)
                    begin
                        if (ph_reg == 3'd1)
                        begin
                            ov_reg    <= 1'b1;
                            oidx_reg  <= oc_reg[IW-1:0];
                            olast_reg <= (oc_reg[IW-1:0] == nm1);
                            ph_reg    <= '0;
                            if (oc_reg[IW-1:0] == nm1)
                            begin
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                oc_reg <= oc_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ov_reg <= 1'b0;
                            ph_reg <= 3'd1;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
            if (state_reg != S_OUT && ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

[rtl/radix2_complex_fft.sv]
// Top level of the radix-2 decimation-in-time complex FFT.
// Depends on r2fft_pkg, r2fft_ctrl, r2fft_datapath, r2fft_ram.
//
//  channel   dir  payload
//  s_axis    in   tdata[15:0] sample_real, [31:16] sample_imag
//  m_axis    out  tdata[5:0] bin_index, [21:6] real, [37:22] imag; tlast frame_last
//  cfg       in   index 0 log2_points, 1 inverse_mode
//
// Samples load at one per cycle. After the last one the single butterfly runs
// N/2*log2N butterflies one at a time, limited by the single read port of the
// point store. Output then reads each point and holds it while stalled. Reset
// is asynchronous; no input is taken while computing or emitting, until the last
// point of the frame has been taken.
module radix2_complex_fft
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_real, sample_imag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // bin_index, bin_real, bin_imag, zero pad
    output logic        m_axis_tlast,   // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    cmd_t                 cmd;
    logic signed [DW-1:0] rd_re, rd_im;
    logic [IW-1:0]        idx;
    logic                 ov;

    assign cfg_ready = 1'b1;

    r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(ov), .out_ready(m_axis_tready), .out_idx(idx),
        .out_last(m_axis_tlast), .cmd(cmd)
    );

    r2fft_datapath u_dp (
        .clk(clk), .cmd(cmd), .in_re(s_axis_tdata[15:0]),
        .in_im(s_axis_tdata[31:16]), .rd_re(rd_re), .rd_im(rd_im)
    );

    // Output data straight from the store read register, held while valid
    assign m_axis_tvalid = ov;
    assign m_axis_tdata  = {2'b00, rd_im, rd_re, idx};
endmodule
